// File: hw/rtl/dithered_sigma_delta_modulator_defines.svh
// Assertion macros shared by the modulator RTL.
`ifndef DITHERED_SIGMA_DELTA_MODULATOR_DEFINES_SVH
`define DITHERED_SIGMA_DELTA_MODULATOR_DEFINES_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define SDM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define SDM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/sdm_pkg.sv
// Types and constants shared by the modulator RTL.
package sdm_pkg;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL1,
    S_CHK,
    S_DIV1,
    S_SAT,
    S_MUL2,
    S_ESTART,
    S_DIV2,
    S_UPD,
    S_OUT
  } sdm_state_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_COUNTER_CLOCK = 2'd0,
    CFG_SAMPLE_RATE   = 2'd1,
    CFG_LOOP_ORDER    = 2'd2,
    CFG_DITHER_ENABLE = 2'd3
  } cfg_idx_e;

  // Loop order code without feedback.
  localparam logic [1:0] ORDER_NONE = 2'd0;

  // Register reset values.
  localparam logic [23:0] CF_RESET     = 24'd1193182;
  localparam logic [17:0] SR_RESET     = 18'd8000;
  localparam logic [1:0]  ORDER_RESET  = 2'd1;
  localparam logic        DITHER_RESET = 1'b1;

  // Noise generator: x^20 + x^3 + 1 in Galois form.
  localparam int unsigned LFSR_W     = 20;
  localparam logic [LFSR_W-1:0] LFSR_TAPS  = 20'h00009;
  localparam logic [LFSR_W-1:0] LFSR_RESET = 20'h00001;

  // Shared divider geometry.
  localparam int unsigned DIV_RW = 26;
  localparam int unsigned DIV_QW = 43;
  localparam int unsigned DIV_CW = 6;
  localparam logic [DIV_CW-1:0] DIV1_STEPS = 6'd17;
  localparam logic [DIV_CW-1:0] DIV2_STEPS = 6'd43;

  // Quotient magnitude limits (18 bits so that overflow is visible).
  localparam logic [17:0] QPOS_MAX = 18'd65535;
  localparam logic [17:0] QNEG_MAX = 18'd65536;
  localparam logic [17:0] Q_OVF    = 18'h20000;

  // Start request toward the divider.
  typedef struct packed {
    logic              start;
    logic [DIV_CW-1:0] steps;
  } div_req_t;

endpackage

// File: hw/rtl/sdm_if.sv
// Handshake channels for input samples and output reload counts.
interface sdm_smp_if;
  logic       valid;
  logic       ready;
  logic [7:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface sdm_res_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] reload_count;

  modport source (output valid, output reload_count, input ready);
  modport sink (input valid, input reload_count, output ready);
endinterface

// File: hw/rtl/sdm_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module sdm_div
  import sdm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  div_req_t          req_i,
  input  logic [DIV_RW-1:0] divisor_i,
  input  logic [DIV_RW-1:0] rem_init_i,
  input  logic [DIV_QW-1:0] dividend_i,
  output logic              busy_o,
  output logic [DIV_QW-1:0] quotient_o
);

  logic              busy_q, busy_d;
  logic [DIV_CW-1:0] cnt_q, cnt_d;
  logic [DIV_RW-1:0] rem_q, rem_d;
  logic [DIV_RW-1:0] dvs_q;
  logic [DIV_QW-1:0] shq_q, shq_d;
  logic [DIV_RW:0]   trial;
  logic [DIV_RW:0]   diff;
  logic              ge;

  // One restoring step: shift in the next dividend bit and try a subtract.
  assign trial = {rem_q, shq_q[DIV_QW-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = (trial >= {1'b0, dvs_q});

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    shq_d  = shq_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.steps;
      rem_d  = rem_init_i;
      shq_d  = dividend_i;
    end else if (busy_q) begin
      rem_d  = ge ? diff[DIV_RW-1:0] : trial[DIV_RW-1:0];
      shq_d  = {shq_q[DIV_QW-2:0], ge};
      cnt_d  = cnt_q - 1'b1;
      busy_d = (cnt_q != {{(DIV_CW-1){1'b0}}, 1'b1});
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operands and partial results.
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    shq_q <= shq_d;
    if (req_i.start) begin
      dvs_q <= divisor_i;
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = shq_q;

endmodule

// File: hw/rtl/dithered_sigma_delta_modulator.sv
// Top level of the dithered sigma-delta modulator.
//
// Usage: samples arrive on smp_i (valid/ready), one unsigned 8-bit sample per
// item. Each item yields exactly one signed 17-bit reload count on res_o
// (valid/ready), in order. Configuration is written through cfg_we_i,
// cfg_idx_i and cfg_wdata_i while the block is idle; a write takes effect at
// the clock edge where cfg_we_i is high.
// Sequence: an accepted item is multiplied, range-checked and divided by the
// shared restoring divider for a 17-bit quotient, which is saturated; the
// saturated value is multiplied again and divided for the fed-back error
// with 43 quotient bits. The integrators are then updated and the result is
// loaded into the output register. The error division is skipped when the
// counter clock is zero, and the quotient division when the product is zero
// or the quotient saturates.
// Intake: smp_i.ready is high only in the idle state, so a new item is
// accepted only after the previous one is loaded into the output register.
// Reset: configuration registers return to their default values, the noise
// register to one, both integrators to zero, and no result is pending.
// Stall: a result waits in the output register; the next item is accepted and
// processed meanwhile, and holds in its last step until the register frees.
`include "dithered_sigma_delta_modulator_defines.svh"

module dithered_sigma_delta_modulator
  import sdm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  sdm_smp_if.sink     smp_i,
  sdm_res_if.source   res_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [23:0] cfg_wdata_i
);

  sdm_state_e state_q, state_d;

  // Configuration registers.
  logic [23:0] cf_q;
  logic [17:0] sr_q;
  logic [1:0]  order_q;
  logic        dith_q;

  // Loop state.
  logic [LFSR_W-1:0] lfsr_q;
  logic [31:0]       int1_q;
  logic [31:0]       int2_q;

  // Per-item working registers.
  logic [7:0]         x_q;
  logic               neg_q;
  logic [31:0]        mag_q;
  logic [55:0]        prod_q;
  logic [17:0]        q_q;
  logic [16:0]        ymag_q;
  logic signed [16:0] y_q;
  logic [31:0]        emag_q;
  logic signed [16:0] out_q;
  logic               out_vld_q;

  // Sequencer outputs.
  logic     accept;
  logic     out_load;
  div_req_t div_req;

  // Divider connections.
  logic [DIV_RW-1:0] div_dvs;
  logic [DIV_RW-1:0] div_rem;
  logic [DIV_QW-1:0] div_dvd;
  logic              div_busy;
  logic [DIV_QW-1:0] div_quo;

  // Intake arithmetic: effective accumulator, noise step and dither.
  logic [31:0]       acc_eff;
  logic              lfsr_bit;
  logic [LFSR_W-1:0] lfsr_nxt;
  logic [32:0]       a_val;
  logic [32:0]       a_abs;

  assign acc_eff  = (order_q == ORDER_NONE) ? {24'd0, smp_i.sample} : int1_q;
  assign lfsr_bit = lfsr_q[LFSR_W-1];
  assign lfsr_nxt = {lfsr_q[LFSR_W-2:0], 1'b0} ^ (lfsr_bit ? LFSR_TAPS : '0);
  assign a_val    = {acc_eff[31], acc_eff} + {32'd0, dith_q & lfsr_bit};
  assign a_abs    = a_val[32] ? (~a_val + 33'd1) : a_val;

  // Shared multiplier: numerator first, then the error numerator.
  logic [31:0] mul_a;
  logic [23:0] mul_b;
  logic [55:0] prod_d;

  assign mul_a  = (state_q == S_MUL1) ? mag_q : {15'd0, ymag_q};
  assign mul_b  = (state_q == S_MUL1) ? cf_q : {6'd0, sr_q};
  assign prod_d = mul_a * mul_b;

  // Range check ahead of the quotient division.
  logic [25:0] den;
  logic [38:0] num_hi;
  logic        prod_zero;
  logic        q_ovf;

  assign den       = {sr_q, 8'd0};
  assign num_hi    = prod_q[55:17];
  assign prod_zero = (prod_q == '0);
  assign q_ovf     = (num_hi >= {13'd0, den});

  // Saturation of the quotient magnitude.
  logic [17:0] sat_mag;
  logic [16:0] y_mag;

  always_comb begin
    if (neg_q) begin
      sat_mag = (q_q > QNEG_MAX) ? QNEG_MAX : q_q;
    end else begin
      sat_mag = (q_q > QPOS_MAX) ? QPOS_MAX : q_q;
    end
  end
  assign y_mag = sat_mag[16:0];

  // Integrator update with the signed error.
  logic [31:0] e32;
  logic [31:0] int2_nxt;

  assign e32      = neg_q ? (~emag_q + 32'd1) : emag_q;
  assign int2_nxt = int2_q + {24'd0, x_q} - e32;

  // Divider operand selection.
  always_comb begin
    if (state_q == S_CHK) begin
      div_dvs = den;
      div_rem = num_hi[25:0];
      div_dvd = {prod_q[16:0], 26'd0};
    end else begin
      div_dvs = {2'd0, cf_q};
      div_rem = '0;
      div_dvd = {prod_q[34:0], 8'd0};
    end
  end

  sdm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .divisor_i  (div_dvs),
    .rem_init_i (div_rem),
    .dividend_i (div_dvd),
    .busy_o     (div_busy),
    .quotient_o (div_quo)
  );

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (smp_i.valid) begin
          state_d = S_MUL1;
        end
      end
      S_MUL1: state_d = S_CHK;
      S_CHK: begin
        state_d = (prod_zero || q_ovf) ? S_SAT : S_DIV1;
      end
      S_DIV1: begin
        if (!div_busy) begin
          state_d = S_SAT;
        end
      end
      S_SAT: begin
        state_d = (cf_q == '0) ? S_UPD : S_MUL2;
      end
      S_MUL2:   state_d = S_ESTART;
      S_ESTART: state_d = S_DIV2;
      S_DIV2: begin
        if (!div_busy) begin
          state_d = S_UPD;
        end
      end
      S_UPD: state_d = S_OUT;
      S_OUT: begin
        if (!out_vld_q || res_o.ready) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    smp_i.ready   = 1'b0;
    out_load      = 1'b0;
    div_req.start = 1'b0;
    div_req.steps = DIV1_STEPS;
    case (state_q)
      S_IDLE: smp_i.ready = 1'b1;
      S_CHK: begin
        div_req.start = !(prod_zero || q_ovf);
      end
      S_ESTART: begin
        div_req.start = 1'b1;
        div_req.steps = DIV2_STEPS;
      end
      S_OUT: out_load = !out_vld_q || res_o.ready;
      default: ;
    endcase
  end

  assign accept = smp_i.valid && smp_i.ready;

  // State, configuration, loop state and output handshake.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cf_q      <= CF_RESET;
      sr_q      <= SR_RESET;
      order_q   <= ORDER_RESET;
      dith_q    <= DITHER_RESET;
      lfsr_q    <= LFSR_RESET;
      int1_q    <= '0;
      int2_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_COUNTER_CLOCK: cf_q    <= cfg_wdata_i;
          CFG_SAMPLE_RATE:   sr_q    <= cfg_wdata_i[17:0];
          CFG_LOOP_ORDER:    order_q <= cfg_wdata_i[1:0];
          CFG_DITHER_ENABLE: dith_q  <= cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (accept) begin
        lfsr_q <= lfsr_nxt;
        if (order_q == ORDER_NONE) begin
          int1_q <= {24'd0, smp_i.sample};
        end
      end else if (state_q == S_UPD) begin
        if (order_q[1]) begin
          int2_q <= int2_nxt;
          int1_q <= int1_q + int2_nxt - e32;
        end else begin
          int1_q <= int1_q + {24'd0, x_q} - e32;
        end
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q   <= smp_i.sample;
      neg_q <= a_val[32];
      mag_q <= a_abs[31:0];
    end
    if (state_q == S_MUL1 || state_q == S_MUL2) begin
      prod_q <= prod_d;
    end
    if (state_q == S_CHK) begin
      q_q <= prod_zero ? 18'd0 : Q_OVF;
    end else if (state_q == S_DIV1 && !div_busy) begin
      q_q <= {1'b0, div_quo[16:0]};
    end
    if (state_q == S_SAT) begin
      ymag_q <= y_mag;
      y_q    <= neg_q ? $signed(~y_mag + 17'd1) : $signed(y_mag);
      emag_q <= '0;
    end else if (state_q == S_DIV2 && !div_busy) begin
      emag_q <= div_quo[31:0];
    end
    if (out_load) begin
      out_q <= y_q;
    end
  end

  assign res_o.valid        = out_vld_q;
  assign res_o.reload_count = out_q;

  // Checks on the sequencer and the noise register.
  `SDM_ASSERT_NEXT(a_busy_after_accept, accept, !smp_i.ready, "accepted an item back to back")
  `SDM_ASSERT_NOW(a_div_idle, state_q == S_IDLE, !div_busy, "divider busy while idle")
  `SDM_ASSERT_NOW(a_lfsr_live, 1'b1, lfsr_q != '0, "noise register stuck at zero")

endmodule

// File: sim/tb_dithered_sigma_delta_modulator.sv
// Self-checking testbench for the dithered sigma-delta modulator.
module tb_dithered_sigma_delta_modulator;
  import sdm_pkg::*;

  // Loop order code from which two integrators cascade.
  localparam logic [1:0] ORDER_SECOND = 2'd2;
  // Quantizer scaling and saturation bounds.
  localparam longint RATE_SCALE = 256;
  localparam longint Y_MAX = 65535;
  localparam longint Y_MIN = -65536;
  // Run shape.
  localparam int PHASES = 10;
  localparam int PHASE_ITEMS = 125;
  localparam int MAX_GAP = 19;
  localparam int END_WAIT = 100;
  localparam int QUIET_LIMIT = 4000;
  localparam int PRINT_LIMIT = 30;

  // Directed script: register writes and samples, some with typed-in results.
  typedef enum bit {ROW_WRITE, ROW_SAMPLE} row_kind_e;
  typedef struct packed {
    row_kind_e         kind;
    cfg_idx_e          idx;
    logic [23:0]       wdata;
    logic [7:0]        sample;
    bit                typed;
    logic signed [16:0] want;
  } script_row_t;

  localparam int SCRIPT_LEN = 41;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic        cfg_we;
  cfg_idx_e    cfg_idx;
  logic [23:0] cfg_wdata;

  sdm_smp_if smp_ch();
  sdm_res_if res_ch();

  dithered_sigma_delta_modulator u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .smp_i      (smp_ch),
    .res_o      (res_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  // Shadow copy of the registers and the loop state.
  logic [23:0] clock_hz;
  logic [17:0] rate_hz;
  logic [1:0]  order;
  logic        dither_on;
  logic [LFSR_W-1:0] noise;
  logic [31:0] acc1;
  logic [31:0] acc2;

  logic signed [16:0] reload_q[$];
  bit gaps_on;
  int err_cnt = 0;
  int n_items = 0;
  int n_results = 0;
  int quiet_cycles = 0;

  script_row_t script [SCRIPT_LEN] = '{
    // Reset state: silent noise bit and empty integrator give zero.
    '{ROW_SAMPLE, CFG_COUNTER_CLOCK, 24'd0, 8'd0, 1'b1, 17'sd0},
    '{ROW_SAMPLE, CFG_COUNTER_CLOCK, 24'd0, 8'd255, 1'b0, 17'sd0},
    '{ROW_SAMPLE, CFG_COUNTER_CLOCK, 24'd0, 8'd128, 1'b0, 17'sd0},
    '{ROW_SAMPLE, CFG_COUNTER_CLOCK, 24'd0, 8'd1, 1'b0, 17'sd0},
    // No feedback, no dither, widest ratio: positive saturation.
    '{ROW_WRITE, CFG_LOOP_ORDER, 24'd0, 8'd0, 1'b0, 17'sd0},
    '{ROW_WRITE, CFG_DITHER_ENABLE, 24'd0, 8'd0, 1'b0, 17'sd0},
    '{ROW_WRITE, CFG_COUNTER_CLOCK, 24'hFFFFFF, 8'd0, 1'b0, 17'sd0},
    '{ROW_WRITE, CFG_SAMPLE_RATE, 24'd1, 8'd0, 1'b0, 17'sd0},
    '{ROW_SAMPLE, CFG_COUNTER_CLOCK, 24'd0, 8'd255, 1'b1, 17'sd65535},
    '{ROW_SAMPLE, CFG_COUNTER_CLOCK, 24'd0, 8'd0, 1'b1, 17'sd0},
    '{ROW_SAMPLE, CFG_COUNTER_CLOCK, 24'd0, 8'd170, 1'b0, 17'sd0},
    '{ROW_SAMPLE, CFG_COUNTER_CLOCK, 24'd0, 8'd85, 1'b0, 17'sd0},
    // Zero sample rate saturates by the sign of the numerator.
    '{ROW_WRITE, CFG_SAMPLE_RATE, 24'd0, 8'd0, 1'b0, 17'sd0},
    '{ROW_SAMPLE, CFG_COUNTER_CLOCK, 24'd0, 8'd1, 1'b1, 17'sd65535},
    '{ROW_SAMPLE, CFG_COUNTER_CLOCK, 24'd0, 8'd0, 1'b1, 17'sd0},
    // Zero counter clock forces a zero numerator.
    '{ROW_WRITE, CFG_COUNTER_CLOCK, 24'd0, 8'd0, 1'b0, 17'sd0},
    '{ROW_SAMPLE, CFG_COUNTER_CLOCK, 24'd0, 8'd255, 1'b1, 17'sd0},
    // Second order with dither at the highest sample rate.
    '{ROW_WRITE, CFG_COUNTER_CLOCK, 24'd1193182, 8'd0, 1'b0, 17'sd0},
    '{ROW_WRITE, CFG_SAMPLE_RATE, 24'd262143, 8'd0, 1'b0, 17'sd0},
    '{ROW_WRITE, CFG_LOOP_ORDER, 24'd2, 8'd0, 1'b0, 17'sd0},
    '{ROW_WRITE, CFG_DITHER_ENABLE, 24'd1, 8'd0, 1'b0, 17'sd0},
    '{ROW_SAMPLE, CFG_COUNTER_CLOCK, 24'd0, 8'd255, 1'b0, 17'sd0},
    '{ROW_SAMPLE, CFG_COUNTER_CLOCK, 24'd0, 8'd255, 1'b0, 17'sd0},
    '{ROW_SAMPLE, CFG_COUNTER_CLOCK, 24'd0, 8'd0, 1'b0, 17'sd0},
    '{ROW_SAMPLE, CFG_COUNTER_CLOCK, 24'd0, 8'd128, 1'b0, 17'sd0},
    // Order three behaves as second order.
    '{ROW_WRITE, CFG_LOOP_ORDER, 24'd3, 8'd0, 1'b0, 17'sd0},
    '{ROW_SAMPLE, CFG_COUNTER_CLOCK, 24'd0, 8'd255, 1'b0, 17'sd0},
    '{ROW_SAMPLE, CFG_COUNTER_CLOCK, 24'd0, 8'd0, 1'b0, 17'sd0},
    '{ROW_SAMPLE, CFG_COUNTER_CLOCK, 24'd0, 8'd64, 1'b0, 17'sd0},
    // Smallest nonzero clock and rate: the error feedback dominates.
    '{ROW_WRITE, CFG_COUNTER_CLOCK, 24'd1, 8'd0, 1'b0, 17'sd0},
    '{ROW_WRITE, CFG_SAMPLE_RATE, 24'd1, 8'd0, 1'b0, 17'sd0},
    '{ROW_WRITE, CFG_LOOP_ORDER, 24'd1, 8'd0, 1'b0, 17'sd0},
    '{ROW_SAMPLE, CFG_COUNTER_CLOCK, 24'd0, 8'd255, 1'b0, 17'sd0},
    '{ROW_SAMPLE, CFG_COUNTER_CLOCK, 24'd0, 8'd255, 1'b0, 17'sd0},
    '{ROW_SAMPLE, CFG_COUNTER_CLOCK, 24'd0, 8'd0, 1'b0, 17'sd0},
    // Widest counter clock against the highest sample rate, first order.
    '{ROW_WRITE, CFG_COUNTER_CLOCK, 24'hFFFFFF, 8'd0, 1'b0, 17'sd0},
    '{ROW_WRITE, CFG_SAMPLE_RATE, 24'd262143, 8'd0, 1'b0, 17'sd0},
    '{ROW_WRITE, CFG_LOOP_ORDER, 24'd1, 8'd0, 1'b0, 17'sd0},
    '{ROW_SAMPLE, CFG_COUNTER_CLOCK, 24'd0, 8'd255, 1'b0, 17'sd0},
    '{ROW_SAMPLE, CFG_COUNTER_CLOCK, 24'd0, 8'd0, 1'b0, 17'sd0},
    '{ROW_SAMPLE, CFG_COUNTER_CLOCK, 24'd0, 8'd255, 1'b0, 17'sd0}
  };

  // Clock.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Quantize one sample, advance the noise and integrator state, return y.
  function automatic logic signed [16:0] quantize_sample(input logic [7:0] x);
    logic noise_bit;
    longint acc_s, d_l, clk_l, rate_l, num, den, y, err;
    logic [31:0] err32;
    if (order == ORDER_NONE) acc1 = {24'd0, x};
    noise_bit = noise[LFSR_W-1];
    noise = {noise[LFSR_W-2:0], 1'b0} ^ (noise_bit ? LFSR_TAPS : '0);
    d_l = dither_on & noise_bit;
    acc_s = $signed(acc1);
    clk_l = clock_hz;
    rate_l = rate_hz;
    num = (acc_s + d_l) * clk_l;
    den = rate_l * RATE_SCALE;
    if (den == 0) y = (num > 0) ? Y_MAX : ((num < 0) ? Y_MIN : 0);
    else y = num / den;
    if (y > Y_MAX) y = Y_MAX;
    if (y < Y_MIN) y = Y_MIN;
    // The error is fed back from the saturated value.
    err = (clk_l == 0) ? 0 : (y * rate_l * RATE_SCALE) / clk_l;
    err32 = err[31:0];
    if (order >= ORDER_SECOND) begin
      acc2 = acc2 + x - err32;
      acc1 = acc1 + acc2 - err32;
    end else begin
      acc1 = acc1 + x - err32;
    end
    return y[16:0];
  endfunction

  // Print one line per failure, up to a limit, and count them all.
  task automatic flag_mismatch(input string msg);
    if (err_cnt < PRINT_LIMIT) $display("[%0t] MISMATCH: %s", $realtime, msg);
    err_cnt++;
  endtask

  // Write one register through the port and into the shadow copy.
  task automatic write_reg(input cfg_idx_e idx, input logic [23:0] val);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      CFG_COUNTER_CLOCK: clock_hz = val;
      CFG_SAMPLE_RATE:   rate_hz = val[17:0];
      CFG_LOOP_ORDER:    order = val[1:0];
      CFG_DITHER_ENABLE: dither_on = val[0];
      default: ;
    endcase
  endtask

  // Offer one sample, after a random gap while gaps are on, and record its expected result.
  task automatic send_sample(input logic [7:0] x, input bit typed,
                             input logic signed [16:0] want);
    int gap;
    logic signed [16:0] predicted;
    gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
    repeat (gap) begin
      @(negedge clk_i);
      smp_ch.valid <= 1'b0;
    end
    @(negedge clk_i);
    smp_ch.valid <= 1'b1;
    smp_ch.sample <= x;
    do @(posedge clk_i); while (!smp_ch.ready);
    predicted = quantize_sample(x);
    reload_q.push_back(typed ? want : predicted);
    n_items++;
  endtask

  // Stop offering samples and wait until every result has come back.
  task automatic drain();
    @(negedge clk_i);
    smp_ch.valid <= 1'b0;
    while (reload_q.size() != 0) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [23:0] pick_clock();
    case ($urandom_range(0, 7))
      0: return 24'd0;
      1: return 24'd1;
      2: return 24'hFFFFFF;
      3: return 24'd1193182;
      default: return 24'($urandom_range(1, 24'hFFFFFF));
    endcase
  endfunction

  function automatic logic [23:0] pick_rate();
    case ($urandom_range(0, 7))
      0: return 24'd0;
      1: return 24'd1;
      2: return 24'd262143;
      3: return 24'd8000;
      4: return 24'd44100;
      default: return 24'($urandom_range(1, 262143));
    endcase
  endfunction

  // Stimulus: reset, directed script, then random phases.
  initial begin
    logic [7:0] x;
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_COUNTER_CLOCK;
    cfg_wdata = '0;
    smp_ch.valid = 1'b0;
    smp_ch.sample = '0;
    clock_hz = CF_RESET;
    rate_hz = SR_RESET;
    order = ORDER_RESET;
    dither_on = DITHER_RESET;
    noise = LFSR_RESET;
    acc1 = '0;
    acc2 = '0;
    gaps_on = 1'b1;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (script[i]) begin
      if (script[i].kind == ROW_WRITE) begin
        drain();
        write_reg(script[i].idx, script[i].wdata);
      end else begin
        send_sample(script[i].sample, script[i].typed, script[i].want);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      drain();
      write_reg(CFG_COUNTER_CLOCK, pick_clock());
      write_reg(CFG_SAMPLE_RATE, pick_rate());
      write_reg(CFG_LOOP_ORDER, 24'($urandom_range(0, 3)));
      write_reg(CFG_DITHER_ENABLE, 24'($urandom_range(0, 1)));
      // Every fourth phase runs back to back on both sides.
      gaps_on = (p % 4 != 3);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        case ($urandom_range(0, 9))
          0: x = 8'd0;
          1: x = 8'd255;
          default: x = 8'($urandom_range(0, 255));
        endcase
        send_sample(x, 1'b0, '0);
      end
    end

    drain();
    repeat (END_WAIT) @(posedge clk_i);
    if (reload_q.size() != 0)
      flag_mismatch($sformatf("%0d reload counts never arrived", reload_q.size()));
    $display("Sent %0d samples over %0d random register settings plus the directed script.",
             n_items, PHASES);
    $display("Compared %0d reload counts; %0d failures.", n_results, err_cnt);
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Result side: random stalls, while gaps are on, before each result is taken.
  initial begin
    int stall;
    res_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
      repeat (stall) begin
        @(negedge clk_i);
        res_ch.ready <= 1'b0;
      end
      @(negedge clk_i);
      res_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!res_ch.valid);
    end
  end

  // Compare each accepted reload count with the oldest expectation.
  always @(posedge clk_i) begin : check_reload
    logic signed [16:0] want;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      n_results++;
      if (reload_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected reload count %0d", res_ch.reload_count));
      end else begin
        want = reload_q.pop_front();
        if (res_ch.reload_count !== want)
          flag_mismatch($sformatf("reload_count got %0d, want %0d",
                                  res_ch.reload_count, want));
      end
    end
  end

  // Watchdog: end the run when no item moves for too long.
  always @(posedge clk_i) begin
    if ((smp_ch.valid && smp_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("Watchdog: no item moved in %0d cycles", QUIET_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/sdm_pkg.sv
hw/rtl/sdm_if.sv
hw/rtl/sdm_div.sv
hw/rtl/dithered_sigma_delta_modulator.sv
sim/tb_dithered_sigma_delta_modulator.sv
